// ===== design/slx_pkg.sv =====
// Shared types, codes, keyword table and helper functions for the script lexer.
package slx_pkg;

  localparam int LINE_BITS_DEF = 24;
  localparam int NKW           = 27;

  // scan modes
  localparam logic [3:0] M_IDLE    = 4'd0;
  localparam logic [3:0] M_NUM     = 4'd1;
  localparam logic [3:0] M_NUMDOT  = 4'd2;
  localparam logic [3:0] M_FRAC    = 4'd3;
  localparam logic [3:0] M_WORD    = 4'd4;
  localparam logic [3:0] M_STR     = 4'd5;
  localparam logic [3:0] M_ESC     = 4'd6;
  localparam logic [3:0] M_COMMENT = 4'd7;
  localparam logic [3:0] M_BANG    = 4'd8;
  localparam logic [3:0] M_EQ      = 4'd9;
  localparam logic [3:0] M_GT      = 4'd10;
  localparam logic [3:0] M_LT      = 4'd11;

  // result kinds
  localparam logic [1:0] K_BYTE  = 2'd0;
  localparam logic [1:0] K_TOKEN = 2'd1;
  localparam logic [1:0] K_ERROR = 2'd2;

  // error codes
  localparam logic E_UNEXP  = 1'b0;
  localparam logic E_UNTERM = 1'b1;

  // token types
  localparam logic [5:0] T_LPAREN  = 6'd0;
  localparam logic [5:0] T_RPAREN  = 6'd1;
  localparam logic [5:0] T_COMMA   = 6'd2;
  localparam logic [5:0] T_LBRACE  = 6'd3;
  localparam logic [5:0] T_RBRACE  = 6'd4;
  localparam logic [5:0] T_COLON   = 6'd5;
  localparam logic [5:0] T_PLUS    = 6'd6;
  localparam logic [5:0] T_MINUS   = 6'd7;
  localparam logic [5:0] T_STAR    = 6'd8;
  localparam logic [5:0] T_SLASH   = 6'd9;
  localparam logic [5:0] T_SEMI    = 6'd10;
  localparam logic [5:0] T_NEWLINE = 6'd11;
  localparam logic [5:0] T_BANG    = 6'd12;
  localparam logic [5:0] T_EQ      = 6'd14;
  localparam logic [5:0] T_GT      = 6'd16;
  localparam logic [5:0] T_LT      = 6'd18;
  localparam logic [5:0] T_STRING  = 6'd20;
  localparam logic [5:0] T_NUMBER  = 6'd21;
  localparam logic [5:0] T_IDENT   = 6'd22;
  localparam logic [5:0] T_KW0     = 6'd23;
  localparam logic [5:0] T_EOF     = 6'd50;

  localparam logic [NKW-1:0] MASK_ALL = '1;

  // keyword text, right aligned, first char in the highest used byte
  localparam logic [71:0] KW_STR [NKW] = '{
    72'("let"), 72'("set"), 72'("print"), 72'("msg"), 72'("playsound"),
    72'("send"), 72'("save"), 72'("load"), 72'("click"), 72'("mousemove"),
    72'("mousedown"), 72'("mouseup"), 72'("mousehold"), 72'("sleep"),
    72'("toggle"), 72'("loop"), 72'("unloop"), 72'("if"), 72'("elif"),
    72'("else"), 72'("end"), 72'("and"), 72'("or"), 72'("true"),
    72'("false"), 72'("group"), 72'("use")
  };

  localparam logic [3:0] KW_LEN [NKW] = '{
    4'd3, 4'd3, 4'd5, 4'd3, 4'd9, 4'd4, 4'd4, 4'd4, 4'd5, 4'd9,
    4'd9, 4'd7, 4'd9, 4'd5, 4'd6, 4'd4, 4'd6, 4'd2, 4'd4,
    4'd4, 4'd3, 4'd3, 4'd2, 4'd4, 4'd5, 4'd5, 4'd3
  };

  typedef struct packed {
    logic [7:0] byte_req;
    logic       end_of_source;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  lexeme_byte;
    logic [5:0]  token_type;
    logic [23:0] line_number;
    logic        error_code;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [3:0]     mode;
    logic [NKW-1:0] mask;
    logic [3:0]     pos;
  } scan_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
           (c == 8'h5f);
  endfunction

  // drop keywords whose char at pos differs from c
  function automatic logic [NKW-1:0] kw_feed(input logic [NKW-1:0] mask,
                                              input logic [3:0] pos,
                                              input logic [7:0] c);
    logic [NKW-1:0] m;
    logic [3:0]     idx;
    logic [7:0]     ch;
    m = mask;
    for (int k = 0; k < NKW; k++) begin
      idx = 4'(KW_LEN[k] - 4'd1 - pos);
      ch  = (pos < KW_LEN[k]) ? KW_STR[k][{idx, 3'b000} +: 8] : 8'h00;
      if (!((pos < KW_LEN[k]) && (ch == c))) m[k] = 1'b0;
    end
    return m;
  endfunction

  // first live keyword of full length, else identifier
  function automatic logic [5:0] kw_type(input logic [NKW-1:0] mask,
                                         input logic [3:0] pos);
    logic [5:0] t;
    t = T_IDENT;
    for (int k = NKW - 1; k >= 0; k--) begin
      if (mask[k] && (KW_LEN[k] == pos)) t = 6'(T_KW0 + 6'(k));
    end
    return t;
  endfunction

  function automatic out_t mk(input logic [1:0] kind, input logic [7:0] b,
                              input logic [5:0] t, input logic e,
                              input logic [23:0] ln);
    out_t r;
    r.kind        = kind;
    r.lexeme_byte = b;
    r.token_type  = t;
    r.line_number = ln;
    r.error_code  = e;
    r.last        = 1'b0;
    return r;
  endfunction

endpackage

// ===== design/slx_step.sv =====
// Next-state and result logic of the lexer for one source word.
module slx_step #(
  parameter int LINE_BITS = slx_pkg::LINE_BITS_DEF
) (
  input  slx_pkg::scan_t       st,
  input  logic [LINE_BITS-1:0] line,
  input  slx_pkg::in_t         din,
  output slx_pkg::scan_t       st_nxt,
  output logic [LINE_BITS-1:0] line_nxt,
  output slx_pkg::out_t        res0,
  output slx_pkg::out_t        res1,
  output logic [1:0]           n_res
);

  slx_pkg::out_t r [2];
  logic [1:0]  n;
  logic        do_idle;
  logic        do_rst;
  logic        do_inc;
  logic [7:0]  c;
  logic [31:0] lw;
  logic [23:0] ln;
  logic [5:0]  op1;

  always_comb begin
    c       = din.byte_req;
    lw      = 32'(line);
    ln      = lw[23:0];
    st_nxt  = st;
    line_nxt = line;
    r[0]    = '0;
    r[1]    = '0;
    n       = 2'd0;
    do_idle = 1'b0;
    do_rst  = 1'b0;
    do_inc  = 1'b0;
    case (st.mode)
      slx_pkg::M_BANG: op1 = slx_pkg::T_BANG;
      slx_pkg::M_EQ:   op1 = slx_pkg::T_EQ;
      slx_pkg::M_GT:   op1 = slx_pkg::T_GT;
      default:         op1 = slx_pkg::T_LT;
    endcase

    if (din.end_of_source) begin
      do_rst = 1'b1;
      case (st.mode)
        slx_pkg::M_NUM, slx_pkg::M_FRAC: begin
          r[n[0]] = slx_pkg::mk(slx_pkg::K_TOKEN, 8'h00, slx_pkg::T_NUMBER, 1'b0, ln);
          n = n + 2'd1;
        end
        slx_pkg::M_WORD: begin
          r[n[0]] = slx_pkg::mk(slx_pkg::K_TOKEN, 8'h00,
                                slx_pkg::kw_type(st.mask, st.pos), 1'b0, ln);
          n = n + 2'd1;
        end
        slx_pkg::M_BANG, slx_pkg::M_EQ, slx_pkg::M_GT, slx_pkg::M_LT: begin
          r[n[0]] = slx_pkg::mk(slx_pkg::K_TOKEN, 8'h00, op1, 1'b0, ln);
          n = n + 2'd1;
        end
        default: ;
      endcase
      if (st.mode == slx_pkg::M_NUMDOT) begin
        r[0] = slx_pkg::mk(slx_pkg::K_TOKEN, 8'h00, slx_pkg::T_NUMBER, 1'b0, ln);
        r[1] = slx_pkg::mk(slx_pkg::K_ERROR, 8'h2e, 6'd0, slx_pkg::E_UNEXP, ln);
        n = 2'd2;
      end else if (st.mode == slx_pkg::M_STR || st.mode == slx_pkg::M_ESC) begin
        r[0] = slx_pkg::mk(slx_pkg::K_ERROR, 8'h00, 6'd0, slx_pkg::E_UNTERM, ln);
        n = 2'd1;
      end else begin
        r[n[0]] = slx_pkg::mk(slx_pkg::K_TOKEN, 8'h00, slx_pkg::T_EOF, 1'b0, ln);
        n = n + 2'd1;
      end
    end else begin
      case (st.mode)
        slx_pkg::M_COMMENT: begin
          if (c == 8'h0a) do_idle = 1'b1;
        end
        slx_pkg::M_NUM, slx_pkg::M_FRAC: begin
          if (slx_pkg::is_digit(c)) begin
            r[0] = slx_pkg::mk(slx_pkg::K_BYTE, c, slx_pkg::T_NUMBER, 1'b0, ln);
            n = 2'd1;
          end else if (c == 8'h2e && st.mode == slx_pkg::M_NUM) begin
            st_nxt.mode = slx_pkg::M_NUMDOT;
          end else begin
            r[0] = slx_pkg::mk(slx_pkg::K_TOKEN, 8'h00, slx_pkg::T_NUMBER, 1'b0, ln);
            n = 2'd1;
            do_idle = 1'b1;
          end
        end
        slx_pkg::M_NUMDOT: begin
          if (slx_pkg::is_digit(c)) begin
            r[0] = slx_pkg::mk(slx_pkg::K_BYTE, 8'h2e, slx_pkg::T_NUMBER, 1'b0, ln);
            r[1] = slx_pkg::mk(slx_pkg::K_BYTE, c, slx_pkg::T_NUMBER, 1'b0, ln);
            n = 2'd2;
            st_nxt.mode = slx_pkg::M_FRAC;
          end else begin
            r[0] = slx_pkg::mk(slx_pkg::K_TOKEN, 8'h00, slx_pkg::T_NUMBER, 1'b0, ln);
            r[1] = slx_pkg::mk(slx_pkg::K_ERROR, 8'h2e, 6'd0, slx_pkg::E_UNEXP, ln);
            n = 2'd2;
            do_rst = 1'b1;
          end
        end
        slx_pkg::M_WORD: begin
          if (slx_pkg::is_alpha(c) || slx_pkg::is_digit(c)) begin
            st_nxt.mask = slx_pkg::kw_feed(st.mask, st.pos, c);
            st_nxt.pos  = (st.pos == 4'd15) ? st.pos : st.pos + 4'd1;
            r[0] = slx_pkg::mk(slx_pkg::K_BYTE, c, slx_pkg::T_IDENT, 1'b0, ln);
            n = 2'd1;
          end else begin
            r[0] = slx_pkg::mk(slx_pkg::K_TOKEN, 8'h00,
                               slx_pkg::kw_type(st.mask, st.pos), 1'b0, ln);
            n = 2'd1;
            do_idle = 1'b1;
          end
        end
        slx_pkg::M_STR: begin
          if (c == 8'h22) begin
            r[0] = slx_pkg::mk(slx_pkg::K_TOKEN, 8'h00, slx_pkg::T_STRING, 1'b0, ln);
            n = 2'd1;
            st_nxt.mode = slx_pkg::M_IDLE;
          end else if (c == 8'h5c) begin
            st_nxt.mode = slx_pkg::M_ESC;
          end else begin
            r[0] = slx_pkg::mk(slx_pkg::K_BYTE, c, slx_pkg::T_STRING, 1'b0, ln);
            n = 2'd1;
            do_inc = (c == 8'h0a);
          end
        end
        slx_pkg::M_ESC: begin
          st_nxt.mode = slx_pkg::M_STR;
          do_inc = (c == 8'h0a);
          n = 2'd1;
          case (c)
            8'h5c: r[0] = slx_pkg::mk(slx_pkg::K_BYTE, 8'h5c, slx_pkg::T_STRING, 1'b0, ln);
            8'h22: r[0] = slx_pkg::mk(slx_pkg::K_BYTE, 8'h22, slx_pkg::T_STRING, 1'b0, ln);
            8'h6e: r[0] = slx_pkg::mk(slx_pkg::K_BYTE, 8'h0a, slx_pkg::T_STRING, 1'b0, ln);
            8'h74: r[0] = slx_pkg::mk(slx_pkg::K_BYTE, 8'h09, slx_pkg::T_STRING, 1'b0, ln);
            8'h72: r[0] = slx_pkg::mk(slx_pkg::K_BYTE, 8'h0d, slx_pkg::T_STRING, 1'b0, ln);
            default: begin
              r[0] = slx_pkg::mk(slx_pkg::K_BYTE, 8'h5c, slx_pkg::T_STRING, 1'b0, ln);
              r[1] = slx_pkg::mk(slx_pkg::K_BYTE, c, slx_pkg::T_STRING, 1'b0, ln);
              n = 2'd2;
            end
          endcase
        end
        slx_pkg::M_BANG, slx_pkg::M_EQ, slx_pkg::M_GT, slx_pkg::M_LT: begin
          st_nxt.mode = slx_pkg::M_IDLE;
          n = 2'd1;
          if (c == 8'h3d) begin
            r[0] = slx_pkg::mk(slx_pkg::K_TOKEN, 8'h00, op1 + 6'd1, 1'b0, ln);
          end else begin
            r[0] = slx_pkg::mk(slx_pkg::K_TOKEN, 8'h00, op1, 1'b0, ln);
            do_idle = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      // start-of-token handling, shared by idle and the token-ending cases
      if (do_idle) begin
        st_nxt.mode = slx_pkg::M_IDLE;
        case (c)
          8'h28, 8'h29, 8'h2c, 8'h7b, 8'h7d, 8'h3a, 8'h2b, 8'h2d, 8'h2a, 8'h2f,
          8'h3b, 8'h0a: begin
            case (c)
              8'h28:   r[n[0]] = slx_pkg::mk(slx_pkg::K_TOKEN, 8'h00, slx_pkg::T_LPAREN, 1'b0, ln);
              8'h29:   r[n[0]] = slx_pkg::mk(slx_pkg::K_TOKEN, 8'h00, slx_pkg::T_RPAREN, 1'b0, ln);
              8'h2c:   r[n[0]] = slx_pkg::mk(slx_pkg::K_TOKEN, 8'h00, slx_pkg::T_COMMA, 1'b0, ln);
              8'h7b:   r[n[0]] = slx_pkg::mk(slx_pkg::K_TOKEN, 8'h00, slx_pkg::T_LBRACE, 1'b0, ln);
              8'h7d:   r[n[0]] = slx_pkg::mk(slx_pkg::K_TOKEN, 8'h00, slx_pkg::T_RBRACE, 1'b0, ln);
              8'h3a:   r[n[0]] = slx_pkg::mk(slx_pkg::K_TOKEN, 8'h00, slx_pkg::T_COLON, 1'b0, ln);
              8'h2b:   r[n[0]] = slx_pkg::mk(slx_pkg::K_TOKEN, 8'h00, slx_pkg::T_PLUS, 1'b0, ln);
              8'h2d:   r[n[0]] = slx_pkg::mk(slx_pkg::K_TOKEN, 8'h00, slx_pkg::T_MINUS, 1'b0, ln);
              8'h2a:   r[n[0]] = slx_pkg::mk(slx_pkg::K_TOKEN, 8'h00, slx_pkg::T_STAR, 1'b0, ln);
              8'h2f:   r[n[0]] = slx_pkg::mk(slx_pkg::K_TOKEN, 8'h00, slx_pkg::T_SLASH, 1'b0, ln);
              8'h3b:   r[n[0]] = slx_pkg::mk(slx_pkg::K_TOKEN, 8'h00, slx_pkg::T_SEMI, 1'b0, ln);
              default: r[n[0]] = slx_pkg::mk(slx_pkg::K_TOKEN, 8'h00, slx_pkg::T_NEWLINE, 1'b0, ln);
            endcase
            n = n + 2'd1;
            do_inc = (c == 8'h0a);
          end
          8'h0d, 8'h20, 8'h09: ;
          8'h23: st_nxt.mode = slx_pkg::M_COMMENT;
          8'h21: st_nxt.mode = slx_pkg::M_BANG;
          8'h3d: st_nxt.mode = slx_pkg::M_EQ;
          8'h3e: st_nxt.mode = slx_pkg::M_GT;
          8'h3c: st_nxt.mode = slx_pkg::M_LT;
          8'h22: st_nxt.mode = slx_pkg::M_STR;
          default: begin
            if (slx_pkg::is_digit(c)) begin
              st_nxt.mode = slx_pkg::M_NUM;
              r[n[0]] = slx_pkg::mk(slx_pkg::K_BYTE, c, slx_pkg::T_NUMBER, 1'b0, ln);
            end else if (slx_pkg::is_alpha(c)) begin
              st_nxt.mode = slx_pkg::M_WORD;
              st_nxt.mask = slx_pkg::kw_feed(slx_pkg::MASK_ALL, 4'd0, c);
              st_nxt.pos  = 4'd1;
              r[n[0]] = slx_pkg::mk(slx_pkg::K_BYTE, c, slx_pkg::T_IDENT, 1'b0, ln);
            end else begin
              r[n[0]] = slx_pkg::mk(slx_pkg::K_ERROR, c, 6'd0, slx_pkg::E_UNEXP, ln);
              do_rst = 1'b1;
            end
            n = n + 2'd1;
          end
        endcase
      end
    end

    if (do_rst) begin
      st_nxt.mode = slx_pkg::M_IDLE;
      st_nxt.mask = slx_pkg::MASK_ALL;
      st_nxt.pos  = 4'd0;
      line_nxt    = LINE_BITS'(1);
    end else if (do_inc && (line != '1)) begin
      line_nxt = line + LINE_BITS'(1);
    end

    if (n == 2'd1) r[0].last = 1'b1;
    if (n == 2'd2) r[1].last = 1'b1;
    res0  = r[0];
    res1  = r[1];
    n_res = n;
  end

endmodule

// ===== design/slx_outq.sv =====
// Four-entry result queue: takes up to two words per cycle, gives one.
module slx_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [1:0]    push_n,
  input  slx_pkg::out_t push0,
  input  slx_pkg::out_t push1,
  output logic          has_room,
  output logic          out_valid,
  input  logic          out_ready,
  output slx_pkg::out_t out_data
);

  slx_pkg::out_t mem [4];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = (cnt_r != 3'd0);
  assign has_room  = (cnt_r <= 3'd2);
  assign out_data  = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r + push_n;
    rp_nxt  = rp_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, push_n} - {2'b00, pop};
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wp_r] <= push0;
    if (push_n == 2'd2) mem[wp_r + 2'd1] <= push1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 3'd4)
    else $error("result queue overfilled");

endmodule

// ===== design/script_lexer_stream_unit.sv =====
// Streaming lexer top level: one source word in, lexeme bytes, tokens and errors out.
//
// Takes one source byte (or an end-of-source mark) per input word and gives
// zero, one or two result words for it, the final one flagged with last.
// Number, identifier and string tokens first stream their decoded bytes
// (kind 0) and then a token-complete word (kind 1); keywords are found by a
// 27-way match mask updated on every identifier byte. Every input word is
// handled in the cycle it is accepted: scan mode, line count and match mask
// are updated there and the results go straight into a four-entry output
// queue. An input word is taken whenever that queue holds two words or fewer,
// so the block accepts one byte per cycle while results are drained at one
// per cycle when out_ready is high; the sustained rate is set by the output
// side. Errors and end of source return the block to its reset state, with
// the line count back to 1. line_number is the line current before the byte.
module script_lexer_stream_unit #(
  parameter int LINE_BITS = slx_pkg::LINE_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  slx_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output slx_pkg::out_t out_data
);

  slx_pkg::scan_t       st_r, st_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt;
  slx_pkg::out_t        res0, res1;
  logic [1:0]           n_res;
  logic                 acc;

  assign acc = in_valid && in_ready;

  slx_step #(.LINE_BITS(LINE_BITS)) u_step (
    .st      (st_r),
    .line    (line_r),
    .din     (in_data),
    .st_nxt  (st_nxt),
    .line_nxt(line_nxt),
    .res0    (res0),
    .res1    (res1),
    .n_res   (n_res)
  );

  // results enter the queue only for an accepted word
  slx_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_n   (acc ? n_res : 2'd0),
    .push0    (res0),
    .push1    (res1),
    .has_room (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode <= slx_pkg::M_IDLE;
      st_r.mask <= slx_pkg::MASK_ALL;
      st_r.pos  <= 4'd0;
      line_r    <= LINE_BITS'(1);
    end else if (acc) begin
      st_r   <= st_nxt;
      line_r <= line_nxt;
    end
  end

  a_line_nz: assert property (@(posedge clk) disable iff (!rst_n) line_r != '0)
    else $error("line count reached zero");

  a_eos_restart: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_data.end_of_source |=> st_r.mode == slx_pkg::M_IDLE && line_r == LINE_BITS'(1))
    else $error("no restart after end of source");

  a_word_pos: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.mode == slx_pkg::M_WORD |-> st_r.pos != 4'd0)
    else $error("word mode with empty identifier");

endmodule
